[src/bcc_pkg.sv]
// shared types, constants and the timer load function for the button click classifier
// no dependencies

package bcc_pkg;

  localparam int TimerW = 16;
  localparam int CfgW = 16;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 4;
  localparam int LoadW = (CfgW > TimerW) ? CfgW : TimerW;

  localparam logic [CfgW-1:0] DebounceReset = CfgW'(20);
  localparam logic [CfgW-1:0] DoubleClickReset = CfgW'(300);
  localparam logic [CfgW-1:0] HoldDelayReset = CfgW'(500);
  localparam logic [CfgW-1:0] RepeatReset = CfgW'(100);

  typedef enum logic [1:0] {
    RegDebounce    = 2'd0,
    RegDoubleClick = 2'd1,
    RegHoldDelay   = 2'd2,
    RegRepeat      = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ReqTick = 1'b0,
    ReqEdge = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ticks;
    logic [CfgW-1:0] double_click_ticks;
    logic [CfgW-1:0] hold_delay_ticks;
    logic [CfgW-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic double_click_event;
    logic hold_event;
    logic debounced_state;
  } result_t;

  localparam logic [LoadW-1:0] TimerMax = LoadW'((64'd1 << TimerW) - 64'd1);
  localparam logic [1:0] ClickMax = 2'd3;

  // zero period counts as one tick, long periods saturate at the timer range
  function automatic logic [TimerW-1:0] load_value(logic [CfgW-1:0] period);
    logic [LoadW-1:0] v;
    v = LoadW'(period);
    if (v == '0) begin
      v = LoadW'(1);
    end
    if (v > TimerMax) begin
      v = TimerMax;
    end
    return v[TimerW-1:0];
  endfunction

endpackage

[src/bcc_if.sv]
// valid/ready channel interfaces for request and result words
// no dependencies

interface bcc_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic button_level;

  modport source (output valid, output req_type, output button_level, input ready);
  modport sink (input valid, input req_type, input button_level, output ready);
endinterface

interface bcc_out_if;
  logic valid;
  logic ready;
  logic double_click_event;
  logic hold_event;
  logic debounced_state;

  modport source (output valid, output double_click_event, output hold_event,
                  output debounced_state, input ready);
  modport sink (input valid, input double_click_event, input hold_event,
                input debounced_state, output ready);
endinterface

[src/bcc_cfg.sv]
// apb register file holding the four tick periods
// depends on bcc_pkg

module bcc_cfg import bcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegDebounce:    cfg_d.debounce_ticks = pwdata[CfgW-1:0];
        RegDoubleClick: cfg_d.double_click_ticks = pwdata[CfgW-1:0];
        RegHoldDelay:   cfg_d.hold_delay_ticks = pwdata[CfgW-1:0];
        RegRepeat:      cfg_d.repeat_ticks = pwdata[CfgW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDebounce:    prdata = ApbDataW'(cfg_q.debounce_ticks);
      RegDoubleClick: prdata = ApbDataW'(cfg_q.double_click_ticks);
      RegHoldDelay:   prdata = ApbDataW'(cfg_q.hold_delay_ticks);
      RegRepeat:      prdata = ApbDataW'(cfg_q.repeat_ticks);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DebounceReset;
      cfg_q.double_click_ticks <= DoubleClickReset;
      cfg_q.hold_delay_ticks <= HoldDelayReset;
      cfg_q.repeat_ticks <= RepeatReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/bcc_core.sv]
// classifier state: click count, debounce, window and hold timers
// depends on bcc_pkg

module bcc_core import bcc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    req_type_i,
  input  logic    level_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [1:0]        clicks_q, clicks_d;
  logic              busy_q, busy_d;
  logic              pressed_q, pressed_d;
  logic [TimerW-1:0] deb_q, deb_d;
  logic [TimerW-1:0] win_q, win_d;
  logic [TimerW-1:0] hold_q, hold_d;
  logic              deb_fire, win_fire, hold_fire;
  logic              dbl, hold;

  always_comb begin
    clicks_d  = clicks_q;
    busy_d    = busy_q;
    pressed_d = pressed_q;
    deb_d     = deb_q;
    win_d     = win_q;
    hold_d    = hold_q;
    dbl       = 1'b0;
    hold      = 1'b0;
    deb_fire  = 1'b0;
    win_fire  = 1'b0;
    hold_fire = 1'b0;
    if (req_type_e'(req_type_i) == ReqEdge) begin
      hold_d = load_value(cfg_i.hold_delay_ticks);
      if (!busy_q && level_i) begin
        if (clicks_q != ClickMax) begin
          clicks_d = clicks_q + 2'd1;
        end
        busy_d = 1'b1;
        deb_d  = load_value(cfg_i.debounce_ticks);
      end
    end else begin
      // running timers count down, firing when they reach zero
      deb_fire  = (deb_q == TimerW'(1));
      win_fire  = (win_q == TimerW'(1));
      hold_fire = (hold_q == TimerW'(1));
      if (deb_q != '0) deb_d = deb_q - TimerW'(1);
      if (win_q != '0) win_d = win_q - TimerW'(1);
      if (hold_q != '0) hold_d = hold_q - TimerW'(1);
      if (win_fire) begin
        if (clicks_q > 2'd1) begin
          dbl       = 1'b1;
          hold_d    = '0;
          hold_fire = 1'b0;
        end
        clicks_d = '0;
      end
      if (hold_fire && level_i) begin
        hold   = 1'b1;
        hold_d = load_value(cfg_i.repeat_ticks);
      end
      if (deb_fire) begin
        pressed_d = level_i;
        busy_d    = 1'b0;
        win_d     = load_value(cfg_i.double_click_ticks);
      end
    end
    res_o.double_click_event = dbl;
    res_o.hold_event         = hold;
    res_o.debounced_state    = pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clicks_q  <= '0;
      busy_q    <= 1'b0;
      pressed_q <= 1'b0;
      deb_q     <= '0;
      win_q     <= '0;
      hold_q    <= '0;
    end else if (step_i) begin
      clicks_q  <= clicks_d;
      busy_q    <= busy_d;
      pressed_q <= pressed_d;
      deb_q     <= deb_d;
      win_q     <= win_d;
      hold_q    <= hold_d;
    end
  end

endmodule

[src/button_click_classifier.sv]
// top level: request register, classifier core, result register, apb registers
// depends on bcc_pkg, bcc_if, bcc_cfg, bcc_core
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      req_type, button_level
//   out_ch    out  valid/ready      double_click_event, hold_event, debounced_state
//   apb       in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// one word per cycle sustained while out_ch is not stalled; an accepted word sits in the
// request register and its result is loaded into the result register when the core
// steps, which needs room in the result register; the result is then offered on out_ch.
// reset clears the timers, click count and flags and loads the default periods.
// a stalled result holds the result register; the request register keeps
// accepting while either stage has room.

module button_click_classifier import bcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  bcc_in_if.sink              in_ch,
  bcc_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    in_vld_q, out_vld_q;
  logic    req_q, lvl_q;
  logic    step, in_take;

  bcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign step = in_vld_q & (~out_vld_q | out_ch.ready);
  assign in_ch.ready = ~in_vld_q | step;
  assign in_take = in_ch.valid & in_ch.ready;

  bcc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .req_type_i (req_q),
    .level_i    (lvl_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ch.ready) in_vld_q <= in_ch.valid;
      if (~out_vld_q | out_ch.ready) out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_ch.req_type;
      lvl_q <= in_ch.button_level;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_ch.valid              = out_vld_q;
  assign out_ch.double_click_event = res_q.double_click_event;
  assign out_ch.hold_event         = res_q.hold_event;
  assign out_ch.debounced_state    = res_q.debounced_state;

endmodule
